[src/bounded_list_insert_delete_dump_assert.svh]
// Assertion helpers for the list block; clk and rst must be in scope.
`ifndef BOUNDED_LIST_INSERT_DELETE_DUMP_ASSERT_SVH
`define BOUNDED_LIST_INSERT_DELETE_DUMP_ASSERT_SVH

// Same-cycle implication.
`define BLLDD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("list block: same-cycle check failed");

// Next-cycle implication.
`define BLLDD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("list block: next-cycle check failed");

`endif

[src/blldd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package blldd_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 32;
  // Wide enough for a length of up to 64
  localparam int LEN_MAX_W    = 7;

  localparam logic [1:0] CMD_FRONT  = 2'd0;
  localparam logic [1:0] CMD_BACK   = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  localparam logic [2:0] OP_HOLD   = 3'd0;
  localparam logic [2:0] OP_FRONT  = 3'd1;
  localparam logic [2:0] OP_BACK   = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_ROTATE = 3'd4;

  typedef struct packed {
    logic [2:0]           op;
    logic [LEN_MAX_W-1:0] idx;
    logic [LEN_MAX_W-1:0] len;
    logic [DATA_W-1:0]    value;
  } ctrl_t;

endpackage
`default_nettype wire

[src/blldd_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module blldd_cell
  import blldd_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  wire logic              clk,
  input  wire ctrl_t             ctrl,
  input  wire logic [DATA_W-1:0] left_d,
  input  wire logic [DATA_W-1:0] right_d,
  input  wire logic [DATA_W-1:0] head_d,
  output logic      [DATA_W-1:0] q
);

  localparam logic [LEN_MAX_W-1:0] MY    = LEN_MAX_W'(INDEX);
  localparam logic [LEN_MAX_W-1:0] MY_P1 = LEN_MAX_W'(INDEX + 1);

  logic [DATA_W-1:0] data, data_next;

  always_comb begin
    data_next = data;
    case (ctrl.op)
      OP_FRONT: begin
        data_next = (MY == '0) ? ctrl.value : left_d;
      end
      OP_BACK: begin
        if (MY == ctrl.len) data_next = ctrl.value;
      end
      OP_DELETE: begin
        if (MY >= ctrl.idx) data_next = right_d;
      end
      OP_ROTATE: begin
        // ring closes at the last valid cell
        if (MY_P1 == ctrl.len) data_next = head_d;
        else if (MY_P1 < ctrl.len) data_next = right_d;
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign q = data;

endmodule
`default_nettype wire

[src/bounded_list_insert_delete_dump.sv]
`timescale 1ns / 1ps
`default_nettype none
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells.
// A command on the slave side (tuser = command, tdata = value) updates the
// list in the cycle it is accepted; the whole list is then sent front to back
// on the master side, tlast on the final item, one item per cycle while the
// sink is ready. A command first updates the list and then dumps it, as the
// cell ring rotates one element per cycle, while the sink is ready, past the
// head cell, which feeds tdata. An empty list dumps one item with element 0
// and the empty flag set; a refused insert into a full list flags every item
// of its dump as dropped.
module bounded_list_insert_delete_dump
  import blldd_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [DATA_W-1:0] s_tdata,  // [31:0] value
  input  wire logic [1:0]        s_tuser,  // [1:0] command
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [DATA_W-1:0] m_tdata,  // [31:0] element
  output logic                   m_tlast,
  output logic      [1:0]        m_tuser   // [0] empty_res, [1] dropped
);

  `include "bounded_list_insert_delete_dump_assert.svh"

  localparam int LEN_W = $clog2(CAPACITY + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic             state, state_next;
  logic [LEN_W-1:0] length, length_next;
  logic [LEN_W-1:0] cnt, cnt_next;
  logic             dropped, dropped_next;

  logic              s_accept, m_accept;
  logic              full, empty, del_ok, ins_cmd;
  ctrl_t             ctrl;
  logic [DATA_W-1:0] cell_q [CAPACITY];

  assign s_accept = s_tvalid && s_tready;
  assign m_accept = m_tvalid && m_tready;
  assign full     = (length == LEN_W'(CAPACITY));
  assign empty    = (length == '0);
  assign ins_cmd  = (s_tuser == CMD_FRONT) || (s_tuser == CMD_BACK);
  // negative or out-of-range indices are ignored
  assign del_ok   = !s_tdata[DATA_W-1] && ({1'b0, s_tdata[DATA_W-2:0]} < DATA_W'(length));

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_DUMP);
  assign m_tdata  = empty ? '0 : cell_q[0];
  assign m_tlast  = empty || ((cnt + LEN_W'(1)) == length);
  assign m_tuser  = {dropped, empty};

  always_comb begin
    ctrl.op     = OP_HOLD;
    ctrl.idx    = s_tdata[LEN_MAX_W-1:0];
    ctrl.len    = LEN_MAX_W'(length);
    ctrl.value  = s_tdata;
    length_next = length;
    if (s_accept) begin
      case (s_tuser)
        CMD_FRONT: begin
          if (!full) begin
            ctrl.op     = OP_FRONT;
            length_next = length + LEN_W'(1);
          end
        end
        CMD_BACK: begin
          if (!full) begin
            ctrl.op     = OP_BACK;
            length_next = length + LEN_W'(1);
          end
        end
        CMD_DELETE: begin
          if (del_ok) begin
            ctrl.op     = OP_DELETE;
            length_next = length - LEN_W'(1);
          end
        end
        default: ctrl.op = OP_HOLD;
      endcase
    end else if (m_accept && !empty) begin
      ctrl.op = OP_ROTATE;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    dropped_next = dropped;
    case (state)
      ST_IDLE: begin
        if (s_accept) begin
          state_next   = ST_DUMP;
          cnt_next     = '0;
          dropped_next = ins_cmd && full;
        end
      end
      ST_DUMP: begin
        if (m_accept) begin
          if (m_tlast) state_next = ST_IDLE;
          else cnt_next = cnt + LEN_W'(1);
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      length  <= '0;
      cnt     <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      length  <= length_next;
      cnt     <= cnt_next;
      dropped <= dropped_next;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] left_d, right_d;
    if (g == 0) begin : g_first
      assign left_d = s_tdata;
    end else begin : g_mid
      assign left_d = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right_d = cell_q[g];
    end else begin : g_inner
      assign right_d = cell_q[g+1];
    end
    blldd_cell #(
      .INDEX(g)
    ) u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .left_d (left_d),
      .right_d(right_d),
      .head_d (cell_q[0]),
      .q      (cell_q[g])
    );
  end

  `BLLDD_ASSERT_IMPL(a_len_bound, 1'b1, length <= LEN_W'(CAPACITY))
  `BLLDD_ASSERT_IMPL(a_one_side, s_tready, !m_tvalid)
  `BLLDD_ASSERT_IMPL(a_empty_single, m_tvalid && empty, m_tlast)
  `BLLDD_ASSERT_NEXT(a_back_to_idle, m_accept && m_tlast, s_tready)

endmodule
`default_nettype wire
